@@ src/mwp_pkg.sv @@
// Shared constants, types and tables of the multi-wave path point generator.
package mwp_pkg;

    localparam int CORDIC_STAGES       = 16;
    localparam int MAX_WAVES           = 64;
    localparam int MAX_POINTS_PER_WAVE = 4095;

    localparam int AMP_W      = 16;
    localparam int WL_W       = 16;
    localparam int WC_W       = 7;
    localparam int PPW_W      = 12;
    localparam int IDX_W      = 18;
    localparam int X_W        = 22;
    localparam int Y_W        = 17;
    localparam int ANG_W      = 16;
    localparam int Q_W        = 16;
    localparam int TOTAL_W    = PPW_W + WC_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // divider: dividend wide enough for index * wavelength
    localparam int DIV_W      = IDX_W + WL_W;
    localparam int TURN_W     = 32;
    localparam int RAD_W      = 31;
    localparam int CORDIC_W   = 34;
    localparam int VEC_W      = 64;

    localparam longint HALF_PI_Q30  = 64'h6487ED51;
    localparam longint INV_GAIN_Q30 = 64'h26DD3B6A;
    localparam longint HEAD_LIMIT   = 25736;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_COUNT      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_PER_WAVE = CFG_IDX_W'(3);

    localparam logic [AMP_W-1:0] RST_AMPLITUDE       = AMP_W'(256);
    localparam logic [WL_W-1:0]  RST_WAVELENGTH      = WL_W'(2560);
    localparam logic [WC_W-1:0]  RST_WAVE_COUNT      = WC_W'(5);
    localparam logic [PPW_W-1:0] RST_POINTS_PER_WAVE = PPW_W'(300);

    // pipeline stage numbers, stage 0 is the input register
    localparam int ST_DA_END  = DIV_W;
    localparam int ST_J       = ST_DA_END + 1;
    localparam int ST_DB_END  = ST_J + DIV_W;
    localparam int ST_RAD     = ST_DB_END + 1;
    localparam int ST_R1_END  = ST_RAD + CORDIC_STAGES;
    localparam int ST_SIN     = ST_R1_END + 1;
    localparam int ST_MUL     = ST_SIN + 1;
    localparam int ST_VEC_IN  = ST_MUL + 1;
    localparam int ST_V_END   = ST_VEC_IN + CORDIC_STAGES;
    localparam int ST_YAW     = ST_V_END + 1;
    localparam int ST_HALF    = ST_YAW + 1;
    localparam int ST_R2_END  = ST_HALF + CORDIC_STAGES;
    localparam int NUM_STAGES = ST_R2_END + 1;

    // side data that rides along the pipeline
    typedef struct packed {
        logic                    oor;
        logic                    last;
        logic [1:0]              q0;
        logic [1:0]              q1;
        logic [X_W-1:0]          x;
        logic signed [Y_W-1:0]   y;
        logic                    zvec;
        logic signed [ANG_W-1:0] head;
    } t_ctx;

    // arctangent of 2^-k in Q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ src/mwp_if.sv @@
// Handshake channels of the path point generator: index in, pose out, register writes.
interface mwp_in_if;
    logic                       valid;
    logic                       ready;
    logic [mwp_pkg::IDX_W-1:0]  point_index;
    modport source (output valid, output point_index, input ready);
    modport sink   (input valid, input point_index, output ready);
endinterface

interface mwp_out_if;
    logic                              valid;
    logic                              ready;
    logic [mwp_pkg::X_W-1:0]           pos_x;
    logic signed [mwp_pkg::Y_W-1:0]    pos_y;
    logic signed [mwp_pkg::ANG_W-1:0]  heading;
    logic signed [mwp_pkg::Q_W-1:0]    quat_z;
    logic signed [mwp_pkg::Q_W-1:0]    quat_w;
    logic                              last_point;
    logic                              out_of_range;
    modport source (output valid, output pos_x, output pos_y, output heading,
                    output quat_z, output quat_w, output last_point,
                    output out_of_range, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input quat_z, input quat_w, input last_point,
                    input out_of_range, output ready);
endinterface

interface mwp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mwp_pkg::CFG_IDX_W-1:0]   index;
    logic [mwp_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/mwp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module mwp_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [mwp_pkg::DIV_W-1:0]  i_num,
    input  logic [mwp_pkg::PPW_W-1:0]  i_rem,
    input  logic [mwp_pkg::PPW_W-1:0]  i_den,
    output logic [mwp_pkg::DIV_W-1:0]  o_quo,
    output logic [mwp_pkg::PPW_W-1:0]  o_rem
);
    localparam int NW = mwp_pkg::DIV_W;
    localparam int RW = mwp_pkg::PPW_W;

    logic [NW-1:0] w_num [0:NW];
    logic [RW-1:0] w_rem [0:NW];

    assign w_num[0] = i_num;
    assign w_rem[0] = i_rem;

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [RW:0]   w_t;
        logic          w_ge;
        logic [RW:0]   w_diff;
        logic [NW-1:0] n_num, r_num;
        logic [RW-1:0] n_rem, r_rem;

        always_comb begin
            w_t    = {w_rem[k], w_num[k][NW-1]};
            w_ge   = (w_t >= {1'b0, i_den});
            w_diff = w_t - {1'b0, i_den};
            n_rem  = w_ge ? w_diff[RW-1:0] : w_t[RW-1:0];
            n_num  = {w_num[k][NW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num <= n_num;
                r_rem <= n_rem;
            end
        end

        assign w_num[k+1] = r_num;
        assign w_rem[k+1] = r_rem;
    end

    assign o_quo = w_num[NW];
    assign o_rem = w_rem[NW];

endmodule

@@ src/mwp_cordic_rot.sv @@
// Pipelined CORDIC in rotation mode: cosine and sine of a Q2.30 angle.
module mwp_cordic_rot (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [mwp_pkg::CORDIC_W-1:0]  i_ang,
    output logic signed [mwp_pkg::CORDIC_W-1:0]  o_cos,
    output logic signed [mwp_pkg::CORDIC_W-1:0]  o_sin
);
    localparam int CW = mwp_pkg::CORDIC_W;
    localparam int NS = mwp_pkg::CORDIC_STAGES;
    localparam logic signed [CW-1:0] INV_GAIN = CW'(mwp_pkg::INV_GAIN_Q30);

    logic signed [CW-1:0] w_x [0:NS];
    logic signed [CW-1:0] w_y [0:NS];
    logic signed [CW-1:0] w_z [0:NS];

    assign w_x[0] = INV_GAIN;
    assign w_y[0] = '0;
    assign w_z[0] = i_ang;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic signed [CW-1:0] w_atan;
        logic signed [CW-1:0] w_dx, w_dy;
        logic signed [CW-1:0] n_x, n_y, n_z;
        logic signed [CW-1:0] r_x, r_y, r_z;

        always_comb begin
            w_atan = $signed({{(CW-32){1'b0}}, mwp_pkg::atan_q30(5'(k))});
            w_dx   = w_y[k] >>> k;
            w_dy   = w_x[k] >>> k;
            if (w_z[k] >= 0) begin
                n_x = w_x[k] - w_dx;
                n_y = w_y[k] + w_dy;
                n_z = w_z[k] - w_atan;
            end else begin
                n_x = w_x[k] + w_dx;
                n_y = w_y[k] - w_dy;
                n_z = w_z[k] + w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
        end

        assign w_x[k+1] = r_x;
        assign w_y[k+1] = r_y;
        assign w_z[k+1] = r_z;
    end

    assign o_cos = w_x[NS];
    assign o_sin = w_y[NS];

endmodule

@@ src/mwp_cordic_vec.sv @@
// Pipelined CORDIC in vectoring mode: angle of a wide (x, y) step vector.
module mwp_cordic_vec (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [mwp_pkg::VEC_W-1:0]     i_x,
    input  logic signed [mwp_pkg::VEC_W-1:0]     i_y,
    output logic signed [mwp_pkg::CORDIC_W-1:0]  o_ang
);
    localparam int CW = mwp_pkg::CORDIC_W;
    localparam int VW = mwp_pkg::VEC_W;
    localparam int NS = mwp_pkg::CORDIC_STAGES;

    logic signed [VW-1:0] w_x [0:NS];
    logic signed [VW-1:0] w_y [0:NS];
    logic signed [CW-1:0] w_z [0:NS];

    assign w_x[0] = i_x;
    assign w_y[0] = i_y;
    assign w_z[0] = '0;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic signed [CW-1:0] w_atan;
        logic signed [VW-1:0] w_sx, w_sy;
        logic signed [VW-1:0] n_x, n_y, r_x, r_y;
        logic signed [CW-1:0] n_z, r_z;

        always_comb begin
            w_atan = $signed({{(CW-32){1'b0}}, mwp_pkg::atan_q30(5'(k))});
            w_sx   = w_y[k] >>> k;
            w_sy   = w_x[k] >>> k;
            if (w_y[k] >= 0) begin
                n_x = w_x[k] + w_sx;
                n_y = w_y[k] - w_sy;
                n_z = w_z[k] + w_atan;
            end else begin
                n_x = w_x[k] - w_sx;
                n_y = w_y[k] + w_sy;
                n_z = w_z[k] - w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
        end

        assign w_x[k+1] = r_x;
        assign w_y[k+1] = r_y;
        assign w_z[k+1] = r_z;
    end

    assign o_ang = w_z[NS];

endmodule

@@ src/multi_wave_path_point_gen.sv @@
// Top level of the multi-wave path point generator.
// Takes one point index per beat and returns one pose per beat: x, y, heading, the
// z/w quaternion parts and the last-point and out-of-range flags. The datapath is a
// single pipeline, so a new index is taken every cycle while the output side keeps
// up; the path from the accepting edge to the output register runs through the two
// 34-step dividers (position and turn fraction) and the three CORDIC passes (sine,
// yaw, half-yaw rotation). A stall on the output freezes the whole pipeline. Register
// writes are taken at once and must only be issued while no beat is in flight.
module multi_wave_path_point_gen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwp_in_if.sink      i_in,
    mwp_out_if.source   o_out,
    mwp_cfg_if.sink     i_cfg
);
    localparam int CW   = mwp_pkg::CORDIC_W;
    localparam int VW   = mwp_pkg::VEC_W;
    localparam int NS   = mwp_pkg::NUM_STAGES;
    localparam int DW   = mwp_pkg::DIV_W;
    localparam int PW   = mwp_pkg::PPW_W;
    localparam int WW   = mwp_pkg::WC_W;
    localparam int AW   = mwp_pkg::AMP_W;
    localparam int LW   = mwp_pkg::WL_W;
    localparam int IW   = mwp_pkg::IDX_W;
    localparam int TW   = mwp_pkg::TOTAL_W;
    localparam int RW   = mwp_pkg::RAD_W;
    localparam int YW   = mwp_pkg::Y_W;
    localparam int HW   = mwp_pkg::ANG_W;
    localparam int QW   = mwp_pkg::Q_W;
    localparam int PAW  = PW + AW;
    localparam int YPW  = AW + 1 + 32;

    localparam logic [PW-1:0] PPW_MAX = PW'(mwp_pkg::MAX_POINTS_PER_WAVE);
    localparam logic [WW-1:0] WC_MAX  = WW'(mwp_pkg::MAX_WAVES);
    localparam logic signed [CW-1:0] HALF_PI   = CW'(mwp_pkg::HALF_PI_Q30);
    localparam logic signed [CW-1:0] HEAD_HALF = CW'(32768);
    localparam logic signed [CW-1:0] HEAD_MAX  = CW'(mwp_pkg::HEAD_LIMIT);
    localparam logic signed [CW-1:0] Q15_HALF  = CW'(16384);
    localparam logic signed [CW-1:0] Q15_MAX   = CW'(32767);
    localparam logic signed [CW-1:0] Q15_MIN   = -CW'(32768);
    localparam logic signed [YPW-1:0] Y_HALF   = YPW'(64'h20000000);
    localparam logic signed [YPW-1:0] Y_MAX    = YPW'(65535);
    localparam logic signed [HW-1:0]  HEAD_MAX_O = HW'(mwp_pkg::HEAD_LIMIT);

    function automatic logic signed [QW-1:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] c;
        t = (v + Q15_HALF) >>> 15;
        c = (t > Q15_MAX) ? Q15_MAX : ((t < Q15_MIN) ? Q15_MIN : t);
        return c[QW-1:0];
    endfunction

    // ---------------- configuration registers
    logic [AW-1:0] r_amp;
    logic [LW-1:0] r_wl;
    logic [WW-1:0] r_wc;
    logic [PW-1:0] r_ppw;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= mwp_pkg::RST_AMPLITUDE;
            r_wl  <= mwp_pkg::RST_WAVELENGTH;
            r_wc  <= mwp_pkg::RST_WAVE_COUNT;
            r_ppw <= mwp_pkg::RST_POINTS_PER_WAVE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mwp_pkg::REG_AMPLITUDE:       r_amp <= i_cfg.data[AW-1:0];
                mwp_pkg::REG_WAVELENGTH:      r_wl  <= i_cfg.data[LW-1:0];
                mwp_pkg::REG_WAVE_COUNT:      r_wc  <= i_cfg.data[WW-1:0];
                mwp_pkg::REG_POINTS_PER_WAVE: r_ppw <= i_cfg.data[PW-1:0];
                default: ;
            endcase
        end
    end

    logic [PW-1:0]  w_p;
    logic [WW-1:0]  w_w;
    logic [TW-1:0]  w_total;
    logic [PAW-1:0] w_pa;

    assign w_p     = (r_ppw > PPW_MAX) ? PPW_MAX : r_ppw;
    assign w_w     = (r_wc > WC_MAX) ? WC_MAX : r_wc;
    assign w_total = {{WW{1'b0}}, w_p} * {{PW{1'b0}}, w_w};
    assign w_pa    = {{AW{1'b0}}, w_p} * {{PW{1'b0}}, r_amp};

    // ---------------- pipeline control
    logic              r_ovld;
    logic              w_en;
    logic              w_acc;
    logic [NS-1:0]     r_vld;
    mwp_pkg::t_ctx     r_ctx [0:NS-1];
    mwp_pkg::t_ctx     n_ctx [0:NS-1];

    assign w_en       = !r_ovld || o_out.ready;
    assign i_in.ready = w_en;
    assign w_acc      = i_in.valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int g = 0; g < NS; g++) begin
                r_ctx[g] <= n_ctx[g];
            end
        end
    end

    // ---------------- stage 0: index, product, range flags
    logic [IW-1:0] r_idx;
    logic [DW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx  <= i_in.point_index;
            r_prod <= {{LW{1'b0}}, i_in.point_index} * {{IW{1'b0}}, r_wl};
        end
    end

    // ---------------- divider A: x quotient and index mod p
    logic [DW-1:0] w_xq, w_mq;
    logic [PW-1:0] w_xr, w_mr;

    mwp_div u_div_x (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_prod), .i_rem ('0), .i_den (w_p),
        .o_quo (w_xq), .o_rem (w_xr)
    );

    mwp_div u_div_mod (
        .i_clk (i_clk), .i_en (w_en), .i_num ({{(DW-IW){1'b0}}, r_idx}), .i_rem ('0),
        .i_den (w_p), .o_quo (w_mq), .o_rem (w_mr)
    );

    // ---------------- this point and the next one within the wave
    logic [PW-1:0] r_j0, r_j1;
    logic [PW:0]   w_j1;

    assign w_j1 = {1'b0, w_mr} + {{PW{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j0 <= w_mr;
            r_j1 <= (w_j1 == {1'b0, w_p}) ? '0 : w_j1[PW-1:0];
        end
    end

    // ---------------- divider B: turn fractions j*2^34/p
    logic [DW-1:0] w_t0q, w_t1q;
    logic [PW-1:0] w_t0r, w_t1r;

    mwp_div u_div_t0 (
        .i_clk (i_clk), .i_en (w_en), .i_num ('0), .i_rem (r_j0), .i_den (w_p),
        .o_quo (w_t0q), .o_rem (w_t0r)
    );

    mwp_div u_div_t1 (
        .i_clk (i_clk), .i_en (w_en), .i_num ('0), .i_rem (r_j1), .i_den (w_p),
        .o_quo (w_t1q), .o_rem (w_t1r)
    );

    // turn in 2^-32 units is the quotient without its two low bits
    logic [RW+30-1:0] w_rad0p, w_rad1p;
    logic [RW-1:0]    r_rad0, r_rad1;

    assign w_rad0p = {{RW{1'b0}}, w_t0q[DW-3:2]} * {{30{1'b0}}, RW'(mwp_pkg::HALF_PI_Q30)};
    assign w_rad1p = {{RW{1'b0}}, w_t1q[DW-3:2]} * {{30{1'b0}}, RW'(mwp_pkg::HALF_PI_Q30)};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad0 <= w_rad0p[RW+30-1:30];
            r_rad1 <= w_rad1p[RW+30-1:30];
        end
    end

    // ---------------- sine of both points
    logic signed [CW-1:0] w_c0, w_s0, w_c1, w_s1;

    mwp_cordic_rot u_rot_p0 (
        .i_clk (i_clk), .i_en (w_en), .i_ang ($signed({{(CW-RW){1'b0}}, r_rad0})),
        .o_cos (w_c0), .o_sin (w_s0)
    );

    mwp_cordic_rot u_rot_p1 (
        .i_clk (i_clk), .i_en (w_en), .i_ang ($signed({{(CW-RW){1'b0}}, r_rad1})),
        .o_cos (w_c1), .o_sin (w_s1)
    );

    logic signed [CW-1:0] w_q0, w_q1;
    logic signed [31:0]   r_s0, r_s1;

    always_comb begin
        case (r_ctx[mwp_pkg::ST_R1_END].q0)
            2'd0:    w_q0 = w_s0;
            2'd1:    w_q0 = w_c0;
            2'd2:    w_q0 = -w_s0;
            default: w_q0 = -w_c0;
        endcase
        case (r_ctx[mwp_pkg::ST_R1_END].q1)
            2'd0:    w_q1 = w_s1;
            2'd1:    w_q1 = w_c1;
            2'd2:    w_q1 = -w_s1;
            default: w_q1 = -w_c1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= w_q0[31:0];
            r_s1 <= w_q1[31:0];
        end
    end

    // ---------------- lateral position and step vector
    logic signed [YPW-1:0] r_yprod;
    logic signed [32:0]    r_diff;
    logic [PAW-1:0]        r_pa;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yprod <= YPW'($signed({1'b0, r_amp})) * YPW'(r_s0);
            r_diff  <= $signed({r_s1[31], r_s1}) - $signed({r_s0[31], r_s0});
            r_pa    <= w_pa;
        end
    end

    logic signed [PAW+33:0] w_vyp;
    logic signed [VW-1:0]   w_vy;
    logic signed [YPW-1:0]  w_yr;
    logic signed [YPW-1:0]  w_yc;
    logic                   w_zvec;
    logic signed [VW-1:0]   r_vx, r_vy;

    assign w_vyp  = (PAW+34)'($signed({1'b0, r_pa})) * (PAW+34)'(r_diff);
    assign w_vy   = {{(VW-PAW-34){w_vyp[PAW+33]}}, w_vyp};
    assign w_yr   = (r_yprod + Y_HALF) >>> 30;
    assign w_yc   = (w_yr > Y_MAX) ? Y_MAX : ((w_yr < -Y_MAX) ? -Y_MAX : w_yr);
    assign w_zvec = (r_wl == '0) && (w_vy == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vx <= $signed({{(VW-LW-30){1'b0}}, r_wl, 30'b0});
            r_vy <= w_vy;
        end
    end

    // ---------------- yaw
    logic signed [CW-1:0] w_vz;
    logic signed [CW-1:0] r_yaw;
    logic signed [CW-1:0] w_yawc;

    mwp_cordic_vec u_vec (
        .i_clk (i_clk), .i_en (w_en), .i_x (r_vx), .i_y (r_vy), .o_ang (w_vz)
    );

    assign w_yawc = (w_vz > HALF_PI) ? HALF_PI : ((w_vz < -HALF_PI) ? -HALF_PI : w_vz);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yaw <= r_ctx[mwp_pkg::ST_V_END].zvec ? '0 : w_yawc;
        end
    end

    logic signed [CW-1:0] w_hr;
    logic signed [CW-1:0] w_hc;
    logic signed [CW-1:0] r_half;

    assign w_hr = (r_yaw + HEAD_HALF) >>> 16;
    assign w_hc = (w_hr > HEAD_MAX) ? HEAD_MAX : ((w_hr < -HEAD_MAX) ? -HEAD_MAX : w_hr);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_half <= r_yaw >>> 1;
        end
    end

    // ---------------- quaternion of the yaw
    logic signed [CW-1:0] w_qc, w_qs;

    mwp_cordic_rot u_rot_quat (
        .i_clk (i_clk), .i_en (w_en), .i_ang (r_half), .o_cos (w_qc), .o_sin (w_qs)
    );

    // ---------------- side data updates along the pipeline
    always_comb begin
        n_ctx[0]      = '0;
        n_ctx[0].oor  = ({1'b0, i_in.point_index} >= w_total);
        n_ctx[0].last = (({2'b0, i_in.point_index} + (TW+1)'(1)) == {1'b0, w_total});
        for (int g = 1; g < NS; g++) begin
            n_ctx[g] = r_ctx[g-1];
        end
        n_ctx[mwp_pkg::ST_J].x       = w_xq[mwp_pkg::X_W-1:0];
        n_ctx[mwp_pkg::ST_RAD].q0    = w_t0q[DW-1:DW-2];
        n_ctx[mwp_pkg::ST_RAD].q1    = w_t1q[DW-1:DW-2];
        n_ctx[mwp_pkg::ST_VEC_IN].y    = w_yc[YW-1:0];
        n_ctx[mwp_pkg::ST_VEC_IN].zvec = w_zvec;
        n_ctx[mwp_pkg::ST_HALF].head = w_hc[HW-1:0];
    end

    // ---------------- output register
    mwp_pkg::t_ctx w_oc;
    logic [mwp_pkg::X_W-1:0]  r_ox;
    logic signed [YW-1:0]     r_oy;
    logic signed [HW-1:0]     r_oh;
    logic signed [QW-1:0]     r_oqz, r_oqw;
    logic                     r_olast, r_ooor;

    assign w_oc = r_ctx[mwp_pkg::ST_R2_END];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ooor  <= w_oc.oor;
            r_olast <= w_oc.oor ? 1'b0 : w_oc.last;
            r_ox    <= w_oc.oor ? '0 : w_oc.x;
            r_oy    <= w_oc.oor ? '0 : w_oc.y;
            r_oh    <= w_oc.oor ? '0 : w_oc.head;
            r_oqz   <= w_oc.oor ? '0 : to_q15(w_qs);
            r_oqw   <= w_oc.oor ? '0 : to_q15(w_qc);
        end
    end

    assign o_out.valid        = r_ovld;
    assign o_out.pos_x        = r_ox;
    assign o_out.pos_y        = r_oy;
    assign o_out.heading      = r_oh;
    assign o_out.quat_z       = r_oqz;
    assign o_out.quat_w       = r_oqw;
    assign o_out.last_point   = r_olast;
    assign o_out.out_of_range = r_ooor;

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.out_of_range |-> o_out.pos_x == '0 && o_out.pos_y == '0 &&
        o_out.heading == '0 && o_out.quat_z == '0 && o_out.quat_w == '0 &&
        !o_out.last_point)
        else $error("out-of-range beat carries a nonzero pose");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.last_point && o_out.out_of_range))
        else $error("last point and out of range both set");

    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.heading <= HEAD_MAX_O && o_out.heading >= -HEAD_MAX_O)
        else $error("heading outside its range");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_vld == $past(r_vld) && r_ovld)
        else $error("pipeline moved during an output stall");
`endif

endmodule

@@ tb/mwp_pose_checker.sv @@
// Pose checker: watches the channels, predicts each pose and compares it with the block's output.
module mwp_pose_checker
    import mwp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mwp_in_if    i_in,
    mwp_out_if   i_out,
    mwp_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [X_W-1:0]          pos_x;
        logic signed [Y_W-1:0]   pos_y;
        logic signed [ANG_W-1:0] heading;
        logic signed [Q_W-1:0]   quat_z;
        logic signed [Q_W-1:0]   quat_w;
        logic                    last_point;
        logic                    out_of_range;
    } t_pose;

    localparam longint ARCTAN [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    logic [AMP_W-1:0] amp_q;
    logic [WL_W-1:0]  wl_q;
    logic [WC_W-1:0]  waves_q;
    logic [PPW_W-1:0] ppw_q;
    t_pose            pose_q[$];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = INV_GAIN_Q30;
        y = 0;
        z = ang;
        for (int k = 0; k < CORDIC_STAGES && k < 32; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN[k];
            end else begin
                x += dx; y -= dy; z += ARCTAN[k];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint vector_angle(input longint vx, input longint vy);
        longint x, y, z, sx, sy;
        x = vx;
        y = vy;
        z = 0;
        for (int k = 0; k < CORDIC_STAGES && k < 32; k++) begin
            sx = y >>> k;
            sy = x >>> k;
            if (y >= 0) begin
                x += sx; y -= sy; z += ARCTAN[k];
            end else begin
                x -= sx; y += sy; z -= ARCTAN[k];
            end
        end
        return z;
    endfunction

    // sine of point j of a wave with p points, Q2.30
    function automatic longint wave_sine(input longint j, input longint p);
        longint turn, frac, rad, c, s;
        turn = ((j << 32) / p) & 64'hFFFF_FFFF;
        frac = turn & 64'h3FFF_FFFF;
        rad  = (frac * HALF_PI_Q30) >> 30;
        rotate(rad, c, s);
        case (turn >> 30)
            0:       return s;
            1:       return c;
            2:       return -s;
            default: return -c;
        endcase
    endfunction

    function automatic longint q15(input longint v);
        return clip((v + (64'sd1 <<< 14)) >>> 15, -32768, 32767);
    endfunction

    function automatic t_pose predict_pose(input logic [IDX_W-1:0] idx);
        t_pose  r;
        longint w, p, total, i, j0, j1, s0, s1, y, vx, vy, yaw, c, s;
        i = idx;
        w = (waves_q > MAX_WAVES) ? MAX_WAVES : waves_q;
        p = (ppw_q > MAX_POINTS_PER_WAVE) ? MAX_POINTS_PER_WAVE : ppw_q;
        total = p * w;
        r = '{default: '0};
        if (i >= total) begin
            r.out_of_range = 1'b1;
            return r;
        end
        r.pos_x = X_W'((i * longint'(wl_q)) / p);
        j0 = i % p;
        j1 = (j0 + 1 == p) ? 0 : j0 + 1;
        s0 = wave_sine(j0, p);
        s1 = wave_sine(j1, p);
        y = (longint'(amp_q) * s0 + (64'sd1 <<< 29)) >>> 30;
        r.pos_y = Y_W'(clip(y, -65535, 65535));
        vx = longint'(wl_q) <<< 30;
        vy = p * longint'(amp_q) * (s1 - s0);
        if (vx == 0 && vy == 0)
            yaw = 0;
        else
            yaw = clip(vector_angle(vx, vy), -HALF_PI_Q30, HALF_PI_Q30);
        r.heading = ANG_W'(clip((yaw + (64'sd1 <<< 15)) >>> 16, -HEAD_LIMIT, HEAD_LIMIT));
        rotate(yaw >>> 1, c, s);
        r.quat_z = Q_W'(q15(s));
        r.quat_w = Q_W'(q15(c));
        r.last_point = (i == total - 1);
        return r;
    endfunction

    task automatic report(input string field, input longint want, input longint got);
        $display("[%0t] pose mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
        o_errors++;
    endtask

    initial o_errors = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            amp_q   = RST_AMPLITUDE;
            wl_q    = RST_WAVELENGTH;
            waves_q = RST_WAVE_COUNT;
            ppw_q   = RST_POINTS_PER_WAVE;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_AMPLITUDE:       amp_q   = i_cfg.data[AMP_W-1:0];
                    REG_WAVELENGTH:      wl_q    = i_cfg.data[WL_W-1:0];
                    REG_WAVE_COUNT:      waves_q = i_cfg.data[WC_W-1:0];
                    REG_POINTS_PER_WAVE: ppw_q   = i_cfg.data[PPW_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                pose_q.insert(pose_q.size(), predict_pose(i_in.point_index));
            if (i_out.valid && i_out.ready) begin
                if (pose_q.size() == 0) begin
                    $display("[%0t] pose beat with nothing expected", $realtime);
                    o_errors++;
                end else begin
                    want = pose_q.pop_front();
                    if (i_out.pos_x !== want.pos_x)
                        report("pos_x", want.pos_x, i_out.pos_x);
                    if (i_out.pos_y !== want.pos_y)
                        report("pos_y", want.pos_y, i_out.pos_y);
                    if (i_out.heading !== want.heading)
                        report("heading", want.heading, i_out.heading);
                    if (i_out.quat_z !== want.quat_z)
                        report("quat_z", want.quat_z, i_out.quat_z);
                    if (i_out.quat_w !== want.quat_w)
                        report("quat_w", want.quat_w, i_out.quat_w);
                    if (i_out.last_point !== want.last_point)
                        report("last_point", want.last_point, i_out.last_point);
                    if (i_out.out_of_range !== want.out_of_range)
                        report("out_of_range", want.out_of_range, i_out.out_of_range);
                end
            end
        end
        o_pending = pose_q.size();
    end

endmodule

@@ tb/tb_multi_wave_path_point_gen.sv @@
// Testbench top: clock, reset, index and register stimulus, output stalls and the verdict.
module tb_multi_wave_path_point_gen;
    import mwp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int RAND_ITEMS   = 148;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    bit   calm;
    bit   hold_req;

    mwp_in_if  in_ch();
    mwp_out_if out_ch();
    mwp_cfg_if cfg_ch();

    multi_wave_path_point_gen i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mwp_pose_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("** multi_wave_path_point_gen: FAILED **");
        $finish;
    end

    // output side: random stalls, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            out_ch.ready = calm || ($urandom_range(99) >= 6);
        end
    end

    int wc_cur, ppw_cur;

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        if (idx == REG_WAVE_COUNT)      wc_cur  = value & 'h7F;
        if (idx == REG_POINTS_PER_WAVE) ppw_cur = value & 'hFFF;
    endtask

    task automatic send_index(input int idx);
        while (!calm && $urandom_range(99) < 6) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.point_index = IDX_W'(idx);
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (130) @(negedge i_clk);
    endtask

    function automatic int path_len();
        int w, p;
        w = wc_cur > MAX_WAVES ? MAX_WAVES : wc_cur;
        p = ppw_cur > MAX_POINTS_PER_WAVE ? MAX_POINTS_PER_WAVE : ppw_cur;
        return w * p;
    endfunction

    task automatic random_indices(input int n);
        int tot, p, k, sel;
        tot = path_len();
        p = ppw_cur == 0 ? 1 : ppw_cur;
        for (int n_i = 0; n_i < n; n_i++) begin
            sel = $urandom_range(99);
            if (tot > 0 && sel < 70) begin
                send_index($urandom_range(tot - 1));
            end else if (tot > 0 && sel < 80) begin
                // around a wave boundary
                k = $urandom_range(tot / p);
                send_index(k * p - $urandom_range(1));
            end else if (sel < 90) begin
                send_index(tot - 1 + $urandom_range(1));
            end else begin
                send_index($urandom_range(262143));
            end
        end
    endtask

    task automatic set_config(input int amp, input int wl, input int wc, input int ppw);
        write_reg(REG_AMPLITUDE, amp);
        write_reg(REG_WAVELENGTH, wl);
        write_reg(REG_WAVE_COUNT, wc);
        write_reg(REG_POINTS_PER_WAVE, ppw);
    endtask

    initial begin
        int tot;
        int probe_idx [11];
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.point_index = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        calm              = 1'b0;
        hold_req          = 1'b0;
        wc_cur            = RST_WAVE_COUNT;
        ppw_cur           = RST_POINTS_PER_WAVE;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: path ends, wave wrap, out of range
        tot = path_len();
        probe_idx = '{0, 1, 299, 300, 150, 75, 225, tot - 2, tot - 1, tot, 262143};
        foreach (probe_idx[d])
            send_index(probe_idx[d]);
        random_indices(RAND_ITEMS);
        drain();

        // largest settings; long output hold-off while indices keep coming
        set_config(65535, 65535, 64, 4095);
        tot = path_len();
        send_index(tot - 1);
        send_index(tot);
        send_index(4094);
        send_index(4095);
        hold_req = 1'b1;
        random_indices(RAND_ITEMS);
        drain();

        // zero amplitude and wavelength, one point; no idling
        calm = 1'b1;
        set_config(0, 0, 1, 1);
        send_index(0);
        send_index(1);
        random_indices(RAND_ITEMS);
        drain();
        calm = 1'b0;

        // wave count above the limit saturates; unused register index ignored
        set_config(1234, 1, 127, 7);
        write_reg(REG_UNUSED, 16'hFFFF);
        random_indices(RAND_ITEMS / 2);
        drain();
        random_indices(RAND_ITEMS / 2);
        drain();

        // zero points per wave: everything out of range
        set_config(40000, 300, 3, 0);
        random_indices(RAND_ITEMS / 3);
        drain();

        // zero waves, zero wavelength with full amplitude
        set_config(65535, 0, 0, 50);
        random_indices(RAND_ITEMS / 3);
        drain();
        write_reg(REG_WAVE_COUNT, 1);
        random_indices(RAND_ITEMS / 3);
        drain();

        set_config(777, 12345, 10, 2);
        random_indices(RAND_ITEMS);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(1, 64),
                       $urandom_range(1, 400));
            random_indices(RAND_ITEMS);
            drain();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("** multi_wave_path_point_gen: PASSED **");
        else
            $display("** multi_wave_path_point_gen: FAILED **");
        $finish;
    end

endmodule
